### rtl/core/tlv_pkg.sv
`default_nettype none

package tlv_pkg;

  // Screen geometry
  localparam int TEXT_ROWS   = 24;
  localparam int TEXT_COLS   = 40;
  localparam int CELL_WIDTH  = 7;
  localparam int CELL_HEIGHT = 8;

  // Rows at the bottom that stay text in split mode
  localparam int SPLIT_ROWS = 4;

  // Field widths
  localparam int ROW_W   = 5;
  localparam int COL_W   = 6;
  localparam int LINE_W  = 3;
  localparam int DOT_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int GIDX_W  = 6;
  localparam int COLOR_W = 8;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Address and glyph constants
  localparam logic [ADDR_W-1:0] ADDR_BASE        = 11'h400;
  localparam logic [ADDR_W-1:0] ROW_GROUP_STRIDE = 11'h028;
  localparam logic [GIDX_W-1:0] GLYPH_FLIP       = 6'h20;
  localparam logic [COLOR_W-1:0] COLOR_FULL      = 8'hFF;

  // Text attribute in the top two bits of the screen byte
  localparam logic [1:0] ATTR_INVERSE = 2'b00;
  localparam logic [1:0] ATTR_FLASH   = 2'b01;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_TEXT_ON     = 3'd0,
    REG_LORES_ON    = 3'd1,
    REG_HIRES_ON    = 3'd2,
    REG_SPLIT_ON    = 3'd3,
    REG_FLASH_SHOWN = 3'd4
  } tlv_reg_e;

  typedef struct packed {
    logic text_on;
    logic lores_on;
    logic hires_on;
    logic split_on;
    logic flash_shown;
  } tlv_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [LINE_W-1:0] line_in_cell;
    logic [DOT_W-1:0]  dot_in_cell;
    logic [BYTE_W-1:0] screen_byte;
    logic [BYTE_W-1:0] glyph_bits;
  } tlv_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } tlv_rgb_t;

  typedef struct packed {
    logic [ADDR_W-1:0] fetch_addr;
    logic [GIDX_W-1:0] glyph_index;
    tlv_rgb_t          rgb;
  } tlv_pix_t;

  // Low-res 16-color palette
  function automatic tlv_rgb_t palette(input logic [3:0] code);
    tlv_rgb_t c;
    case (code)
      4'h0: c = '{8'd0,   8'd0,   8'd0};
      4'h1: c = '{8'd227, 8'd30,  8'd96};
      4'h2: c = '{8'd96,  8'd78,  8'd189};
      4'h3: c = '{8'd255, 8'd68,  8'd253};
      4'h4: c = '{8'd0,   8'd163, 8'd96};
      4'h5: c = '{8'd156, 8'd156, 8'd156};
      4'h6: c = '{8'd20,  8'd207, 8'd253};
      4'h7: c = '{8'd208, 8'd195, 8'd255};
      4'h8: c = '{8'd96,  8'd114, 8'd3};
      4'h9: c = '{8'd255, 8'd106, 8'd60};
      4'hA: c = '{8'd156, 8'd156, 8'd156};
      4'hB: c = '{8'd255, 8'd160, 8'd163};
      4'hC: c = '{8'd20,  8'd245, 8'd60};
      4'hD: c = '{8'd208, 8'd221, 8'd141};
      4'hE: c = '{8'd114, 8'd255, 8'd208};
      4'hF: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tlv_in_if.sv
`default_nettype none

// Pixel request channel
interface tlv_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlv_pkg::ROW_W-1:0]     cell_row;
  logic [tlv_pkg::COL_W-1:0]     cell_col;
  logic [tlv_pkg::LINE_W-1:0]    line_in_cell;
  logic [tlv_pkg::DOT_W-1:0]     dot_in_cell;
  logic [tlv_pkg::BYTE_W-1:0]    screen_byte;
  logic [tlv_pkg::BYTE_W-1:0]    glyph_bits;

  modport source (
    output valid, cell_row, cell_col, line_in_cell, dot_in_cell, screen_byte, glyph_bits,
    input  ready
  );
  modport sink (
    input  valid, cell_row, cell_col, line_in_cell, dot_in_cell, screen_byte, glyph_bits,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/tlv_out_if.sv
`default_nettype none

// Pixel result channel
interface tlv_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlv_pkg::ADDR_W-1:0]    fetch_addr;
  logic [tlv_pkg::GIDX_W-1:0]    glyph_index;
  logic [tlv_pkg::COLOR_W-1:0]   pixel_red;
  logic [tlv_pkg::COLOR_W-1:0]   pixel_green;
  logic [tlv_pkg::COLOR_W-1:0]   pixel_blue;

  modport source (
    output valid, fetch_addr, glyph_index, pixel_red, pixel_green, pixel_blue,
    input  ready
  );
  modport sink (
    input  valid, fetch_addr, glyph_index, pixel_red, pixel_green, pixel_blue,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/tlv_apb_regs.sv
`default_nettype none

module tlv_apb_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tlv_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tlv_pkg::PDATA_W-1:0]  pwdata,
  output      logic [tlv_pkg::PDATA_W-1:0]  prdata,
  output      logic                         pready,
  output      tlv_pkg::tlv_cfg_t            cfg_o
);

  tlv_pkg::tlv_cfg_t cfg_q, cfg_d;
  tlv_pkg::tlv_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = tlv_pkg::tlv_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        tlv_pkg::REG_TEXT_ON:     cfg_d.text_on     = pwdata[0];
        tlv_pkg::REG_LORES_ON:    cfg_d.lores_on    = pwdata[0];
        tlv_pkg::REG_HIRES_ON:    cfg_d.hires_on    = pwdata[0];
        tlv_pkg::REG_SPLIT_ON:    cfg_d.split_on    = pwdata[0];
        tlv_pkg::REG_FLASH_SHOWN: cfg_d.flash_shown = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{text_on: 1'b1, lores_on: 1'b0, hires_on: 1'b0,
                 split_on: 1'b0, flash_shown: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      tlv_pkg::REG_TEXT_ON:     prdata[0] = cfg_q.text_on;
      tlv_pkg::REG_LORES_ON:    prdata[0] = cfg_q.lores_on;
      tlv_pkg::REG_HIRES_ON:    prdata[0] = cfg_q.hires_on;
      tlv_pkg::REG_SPLIT_ON:    prdata[0] = cfg_q.split_on;
      tlv_pkg::REG_FLASH_SHOWN: prdata[0] = cfg_q.flash_shown;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/tlv_render.sv
`default_nettype none

// Address, glyph index and pixel color for one pixel
module tlv_render (
  input  wire tlv_pkg::tlv_cfg_t  cfg_i,
  input  wire tlv_pkg::tlv_item_t item_i,
  output      tlv_pkg::tlv_pix_t  pix_o
);

  localparam int ROW_CMP_W = tlv_pkg::ROW_W + 1;
  localparam int COL_CMP_W = tlv_pkg::COL_W + 1;
  localparam int DOT_CMP_W = tlv_pkg::DOT_W + 2;

  logic [tlv_pkg::ADDR_W-1:0] row_line_off;
  logic [tlv_pkg::ADDR_W-1:0] row_group_off;
  logic                       on_screen;
  logic                       in_split;
  logic                       show_text;
  logic                       show_lores;
  logic                       inverse;
  logic                       lit;
  logic [3:0]                 lores_code;
  logic [1:0]                 attr;

  // Interleaved address: base + 0x80 per line of group + 0x28 per group + column
  assign row_line_off  = {1'b0, item_i.cell_row[2:0], 7'b0};
  assign row_group_off = tlv_pkg::ADDR_W'(item_i.cell_row[4:3]) * tlv_pkg::ROW_GROUP_STRIDE;

  assign pix_o.fetch_addr = tlv_pkg::ADDR_BASE + row_line_off + row_group_off
                          + tlv_pkg::ADDR_W'(item_i.cell_col);
  assign pix_o.glyph_index = item_i.screen_byte[5:0] ^ tlv_pkg::GLYPH_FLIP;

  // Visible area
  assign on_screen =
      (ROW_CMP_W'(item_i.cell_row) < ROW_CMP_W'(tlv_pkg::TEXT_ROWS)) &&
      (COL_CMP_W'(item_i.cell_col) < COL_CMP_W'(tlv_pkg::TEXT_COLS)) &&
      (DOT_CMP_W'(item_i.dot_in_cell) < DOT_CMP_W'(tlv_pkg::CELL_WIDTH));

  // Mode select; text wins over everything
  assign in_split   = cfg_i.split_on &&
      (ROW_CMP_W'(item_i.cell_row) >=
       ROW_CMP_W'(tlv_pkg::TEXT_ROWS - tlv_pkg::SPLIT_ROWS));
  assign show_text  = cfg_i.text_on || (cfg_i.lores_on && in_split);
  assign show_lores = !cfg_i.text_on && cfg_i.lores_on && !in_split;

  // Text attribute: inverse, flashing, normal
  assign attr    = item_i.screen_byte[7:6];
  assign inverse = (attr == tlv_pkg::ATTR_INVERSE) ||
                   ((attr == tlv_pkg::ATTR_FLASH) && !cfg_i.flash_shown);
  assign lit     = item_i.glyph_bits[item_i.dot_in_cell] ^ inverse;

  // Upper half of the cell takes the low nibble
  assign lores_code =
      (DOT_CMP_W'(item_i.line_in_cell) < DOT_CMP_W'(tlv_pkg::CELL_HEIGHT / 2))
      ? item_i.screen_byte[3:0] : item_i.screen_byte[7:4];

  always_comb begin
    pix_o.rgb = '0;
    if (on_screen && show_text) begin
      pix_o.rgb.green = lit ? tlv_pkg::COLOR_FULL : '0;
    end else if (on_screen && show_lores) begin
      pix_o.rgb = tlv_pkg::palette(lores_code);
    end
  end

endmodule

`default_nettype wire

### rtl/core/text_lores_video_pixel_gen.sv
// Text / low-res pixel generator, two register stages (input, result).
// Throughput: one pixel per cycle while the output is not stalled; the input
// register refills as the result register drains, so ready follows the result
// side within the same cycle.
// Reset (async, active low): pipeline empty, text_on and flash_shown set,
// other mode bits clear.
`default_nettype none

module text_lores_video_pixel_gen (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tlv_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tlv_pkg::PDATA_W-1:0]  pwdata,
  output      logic [tlv_pkg::PDATA_W-1:0]  prdata,
  output      logic                         pready,
  tlv_in_if.sink                            in_if,
  tlv_out_if.source                         out_if
);

  tlv_pkg::tlv_cfg_t  cfg;
  tlv_pkg::tlv_item_t s1_q, s1_d;
  tlv_pkg::tlv_pix_t  s2_q, s2_d;
  logic               s1_valid_q, s2_valid_q;
  logic               s1_adv, in_fire;

  tlv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage handshake
  assign s1_adv      = !s2_valid_q || out_if.ready;
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  assign s1_d = '{cell_row:     in_if.cell_row,
                  cell_col:     in_if.cell_col,
                  line_in_cell: in_if.line_in_cell,
                  dot_in_cell:  in_if.dot_in_cell,
                  screen_byte:  in_if.screen_byte,
                  glyph_bits:   in_if.glyph_bits};

  tlv_render u_render (
    .cfg_i  (cfg),
    .item_i (s1_q),
    .pix_o  (s2_d)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_if.valid       = s2_valid_q;
  assign out_if.fetch_addr  = s2_q.fetch_addr;
  assign out_if.glyph_index = s2_q.glyph_index;
  assign out_if.pixel_red   = s2_q.rgb.red;
  assign out_if.pixel_green = s2_q.rgb.green;
  assign out_if.pixel_blue  = s2_q.rgb.blue;

  // A filled input stage that moves on always lands in the result stage
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> s2_valid_q)
    else $error("result stage empty after input stage advanced");

  // Glyph index carries the low six bits of the request's byte through with bit 5 flipped
  a_glyph_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=>
      (out_if.glyph_index == ($past(s1_q.screen_byte[5:0]) ^ tlv_pkg::GLYPH_FLIP)))
    else $error("glyph index mismatch");

  // A dot past the cell width is always black
  a_dot_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv &&
     ((tlv_pkg::DOT_W + 2)'(s1_q.dot_in_cell) >= (tlv_pkg::DOT_W + 2)'(tlv_pkg::CELL_WIDTH)))
    |=> (out_if.pixel_red == '0 && out_if.pixel_green == '0 && out_if.pixel_blue == '0))
    else $error("pixel outside the cell is not black");

endmodule

`default_nettype wire
